// ===== hw/rtl/kdlp_pkg.sv =====
package kdlp_pkg;

  // Configuration register file layout
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TICK_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;

  localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST   = 16'd25;
  localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RST = 16'd650;

  // Event codes; direction key i (i >= 1) reports as EVT_DIR_BASE + i - 1
  localparam int unsigned EVT_SHORT    = 0;
  localparam int unsigned EVT_LONG     = 1;
  localparam int unsigned EVT_DIR_BASE = 2;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] long_press_ticks;
  } cfg_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// ===== hw/rtl/keypad_debounce_long_press_core.sv =====
// Keypad debouncer with select long press.
//
// Input channel: one transaction per millisecond sample of the key levels
// (keys_raw_i: bit0 select, then up, down, left, right), accepted when
// in_valid_i is high and in_stall_o is low. Output channel: one transaction
// per key event (key_event_o, stable_keys_o, last_event_o), taken when
// out_valid_o is high and out_stall_i is low; last_event_o marks the final
// event of a sample. A quiet sample gives no output transaction.
// Configuration: cfg_valid_i/cfg_ready_o write channel, cfg_index_i selects
// debounce_ticks (0) or long_press_ticks (1); other indexes are ignored.
// A sample's events pass through the event queue, the work register and the
// output register. Throughput: a sample is accepted every cycle while the
// 4-entry event queue has room; the back end drains one event per cycle while
// the receiver does not stall, and a sample gives at most KEY_COUNT events.
// Reset clears all key state, the queue and the output register, and loads
// the default thresholds (25 and 650 ticks). A stalled receiver holds the
// output register; the queue keeps taking samples until full, then
// in_stall_o rises.
module keypad_debounce_long_press_core #(
  parameter int unsigned AGE_BITS  = 16,
  parameter int unsigned KEY_COUNT = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [kdlp_pkg::TICK_W-1:0]            cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [KEY_COUNT-1:0]                   keys_raw_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [$clog2(KEY_COUNT+1)-1:0]         key_event_o,
  output logic [KEY_COUNT-1:0]                   stable_keys_o,
  output logic                                   last_event_o
);
  import kdlp_pkg::*;

  localparam int unsigned JOB_W   = 2 * KEY_COUNT + 1;
  localparam int unsigned Q_DEPTH = 4;

  cfg_t             cfg_q;
  q_req_t           q_req;
  q_stat_t          q_stat;
  logic [JOB_W-1:0] job_in;
  logic [JOB_W-1:0] job_out;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DEBOUNCE_TICKS_RST;
      cfg_q.long_press_ticks <= LONG_PRESS_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      priority if (cfg_index_i == REG_DEBOUNCE_TICKS) begin
        cfg_q.debounce_ticks <= cfg_data_i;
      end else if (cfg_index_i == REG_LONG_PRESS_TICKS) begin
        cfg_q.long_press_ticks <= cfg_data_i;
      end else begin
        cfg_q <= cfg_q;
      end
    end
  end

  kdlp_front #(
    .AGE_BITS  (AGE_BITS),
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .keys_raw_i (keys_raw_i),
    .q_stat_i   (q_stat),
    .push_o     (q_req.push),
    .job_o      (job_in)
  );

  kdlp_queue #(
    .WIDTH (JOB_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (q_req),
    .stat_o (q_stat),
    .data_i (job_in),
    .data_o (job_out)
  );

  kdlp_back #(
    .KEY_COUNT (KEY_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_stat.valid),
    .job_i         (job_out),
    .pop_o         (q_req.pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .key_event_o   (key_event_o),
    .stable_keys_o (stable_keys_o),
    .last_event_o  (last_event_o)
  );

  // A sample with more events keeps the output busy on the next cycle
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_event_o |=> out_valid_o)
    else $error("event burst broken before its last event");

  // All events of one sample carry the same stable mask
  a_burst_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_event_o |=>
      stable_keys_o == $past(stable_keys_o))
    else $error("stable mask changed inside one sample's events");

  // Event codes stay within the key range
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, key_event_o} <= ($bits(key_event_o) + 1)'(KEY_COUNT)))
    else $error("event code out of range");

endmodule

// ===== hw/rtl/kdlp_front.sv =====
module kdlp_front #(
  parameter int unsigned AGE_BITS  = 16,
  parameter int unsigned KEY_COUNT = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kdlp_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [KEY_COUNT-1:0]   keys_raw_i,
  input  kdlp_pkg::q_stat_t      q_stat_i,
  output logic                   push_o,
  // {long, pending events, stable mask}
  output logic [2*KEY_COUNT:0]   job_o
);
  import kdlp_pkg::*;

  localparam int unsigned CMP_W = (AGE_BITS > TICK_W) ? AGE_BITS : TICK_W;

  logic [KEY_COUNT-1:0] raw_prev_q, raw_prev_d;
  logic [KEY_COUNT-1:0] stable_q, stable_d;
  logic [AGE_BITS-1:0]  age_q, age_d;
  logic                 held_q, held_d;
  logic [AGE_BITS-1:0]  sel_age_q, sel_age_d;
  logic                 fired_q, fired_d;

  logic                 accept;
  logic                 sel_evt;
  logic                 sel_long;
  logic [KEY_COUNT-1:0] rising;
  logic [KEY_COUNT-1:0] pend;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  // Raw mask age and debounce
  always_comb begin
    raw_prev_d = keys_raw_i;
    if (keys_raw_i != raw_prev_q) begin
      age_d = '0;
    end else if (age_q == {AGE_BITS{1'b1}}) begin
      age_d = age_q;
    end else begin
      age_d = age_q + AGE_BITS'(1);
    end
    if (CMP_W'(age_d) >= CMP_W'(cfg_i.debounce_ticks)) begin
      stable_d = keys_raw_i;
    end else begin
      stable_d = stable_q;
    end
    rising = stable_d & ~stable_q;
  end

  // Select hold timing on the raw level
  always_comb begin
    sel_evt   = 1'b0;
    sel_long  = 1'b0;
    held_d    = held_q;
    sel_age_d = sel_age_q;
    fired_d   = fired_q;
    if (keys_raw_i[0]) begin
      if (!held_q) begin
        held_d    = 1'b1;
        sel_age_d = '0;
        fired_d   = 1'b0;
      end else begin
        if (sel_age_q != {AGE_BITS{1'b1}}) begin
          sel_age_d = sel_age_q + AGE_BITS'(1);
        end
        if (!fired_q && (CMP_W'(sel_age_d) >= CMP_W'(cfg_i.long_press_ticks))) begin
          sel_evt  = 1'b1;
          sel_long = 1'b1;
          fired_d  = 1'b1;
        end
      end
    end else begin
      sel_evt   = held_q && !fired_q;
      held_d    = 1'b0;
      sel_age_d = '0;
      fired_d   = 1'b0;
    end
  end

  // Bit 0 is the select event, the rest are direction key edges
  assign pend   = {rising[KEY_COUNT-1:1], sel_evt};
  assign push_o = accept && (pend != '0);
  assign job_o  = {sel_long, pend, stable_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_prev_q <= '0;
      stable_q   <= '0;
      age_q      <= {AGE_BITS{1'b1}};
      held_q     <= 1'b0;
      sel_age_q  <= '0;
      fired_q    <= 1'b0;
    end else if (accept) begin
      raw_prev_q <= raw_prev_d;
      stable_q   <= stable_d;
      age_q      <= age_d;
      held_q     <= held_d;
      sel_age_q  <= sel_age_d;
      fired_q    <= fired_d;
    end
  end

endmodule

// ===== hw/rtl/kdlp_queue.sv =====
module kdlp_queue #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kdlp_pkg::q_req_t     req_i,
  output kdlp_pkg::q_stat_t    stat_o,
  input  logic [WIDTH-1:0]     data_i,
  output logic [WIDTH-1:0]     data_o
);
  import kdlp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign data_o       = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (req_i.push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (req_i.pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      unique case ({req_i.push, req_i.pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/kdlp_back.sv =====
module kdlp_back #(
  parameter int unsigned KEY_COUNT = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  logic [2*KEY_COUNT:0]           job_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [$clog2(KEY_COUNT+1)-1:0] key_event_o,
  output logic [KEY_COUNT-1:0]           stable_keys_o,
  output logic                           last_event_o
);
  import kdlp_pkg::*;

  localparam int unsigned EVT_W = $clog2(KEY_COUNT + 1);

  logic                 work_valid_q;
  logic [KEY_COUNT-1:0] pend_q;
  logic                 long_q;
  logic [KEY_COUNT-1:0] stable_q;

  logic                 out_valid_q;
  logic [EVT_W-1:0]     event_q;
  logic [KEY_COUNT-1:0] out_stable_q;
  logic                 last_q;

  logic                 load_out;
  logic                 emit;
  logic [KEY_COUNT-1:0] pick;
  logic [KEY_COUNT-1:0] rest;
  logic                 last;
  logic [EVT_W-1:0]     code;
  logic                 found;

  assign load_out = !out_valid_q || !out_stall_i;
  assign emit     = load_out && work_valid_q;

  // Lowest pending event goes first: select, then up, down, left, right
  always_comb begin
    pick  = '0;
    found = 1'b0;
    code  = EVT_W'(EVT_SHORT);
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (pend_q[i] && !found) begin
        found   = 1'b1;
        pick[i] = 1'b1;
        if (i == 0) begin
          code = long_q ? EVT_W'(EVT_LONG) : EVT_W'(EVT_SHORT);
        end else begin
          code = EVT_W'(EVT_DIR_BASE + i - 1);
        end
      end
    end
  end

  assign rest  = pend_q & ~pick;
  assign last  = (rest == '0);
  assign pop_o = q_valid_i && (!work_valid_q || (emit && last));

  // Work register holding the transaction being unpacked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
    end else if (pop_o) begin
      work_valid_q <= 1'b1;
    end else if (emit && last) begin
      work_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      long_q   <= job_i[2*KEY_COUNT];
      pend_q   <= job_i[2*KEY_COUNT-1:KEY_COUNT];
      stable_q <= job_i[KEY_COUNT-1:0];
    end else if (emit) begin
      pend_q <= rest;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      event_q      <= code;
      out_stable_q <= stable_q;
      last_q       <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_event_o   = event_q;
  assign stable_keys_o = out_stable_q;
  assign last_event_o  = last_q;

endmodule
